[hdl/lbcnd_pkg.sv]
// Shared types and constants of the LED blink code number display.
`default_nettype none

package lbcnd_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int BCD_DIGITS = 10;
   localparam int COUNT_W    = 4;
   localparam int TICK_W     = 16;
   localparam int PRE_W      = 4;
   localparam int CSR_IDX_W  = 8;

   localparam logic [TICK_W-1:0] FAST_HALF_RESET = 16'd11;
   localparam logic [TICK_W-1:0] SLOW_HALF_RESET = 16'd45;
   localparam logic [TICK_W-1:0] BREAK_RESET     = 16'd189;
   localparam logic [PRE_W-1:0]  PREAMBLE_RESET  = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_HALF = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_HALF = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE  = 8'd3;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic finished;
   } rsp_type;

   typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] count;
   } conv_status_type;

endpackage

`default_nettype wire

[hdl/lbcnd_bcd_conv.sv]
// Iterative binary to BCD converter with significant digit count.
`default_nettype none

module lbcnd_bcd_conv (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire  [lbcnd_pkg::VALUE_W-1:0]     value,
   output lbcnd_pkg::bcd_type                digits,
   output lbcnd_pkg::conv_status_type        status
);

   localparam int SHIFT_CNT_W = $clog2(lbcnd_pkg::VALUE_W);

   typedef enum logic [2:0] {
      CV_IDLE  = 3'b001,
      CV_SHIFT = 3'b010,
      CV_COUNT = 3'b100
   } conv_state_type;

   conv_state_type                     state_ff, state_in;
   logic [SHIFT_CNT_W-1:0]             cnt_ff, cnt_in;
   logic [lbcnd_pkg::VALUE_W-1:0]      bin_ff, bin_in;
   lbcnd_pkg::bcd_type                 bcd_ff, bcd_in;
   logic [lbcnd_pkg::COUNT_W-1:0]      count_ff, count_in;
   lbcnd_pkg::bcd_type                 adj;
   logic [lbcnd_pkg::BCD_DIGITS*lbcnd_pkg::DIGIT_W-1:0] adj_bits;
   logic [lbcnd_pkg::COUNT_W-1:0]      sig_count;

   // Add three to every digit of five or more before each shift.
   always_comb begin
      for (int i = 0; i < lbcnd_pkg::BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   assign adj_bits = adj;

   // Position of the highest nonzero digit; zero still shows one digit.
   always_comb begin
      sig_count = lbcnd_pkg::COUNT_W'(1);
      for (int i = 0; i < lbcnd_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            sig_count = lbcnd_pkg::COUNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      case (state_ff)
         CV_IDLE: begin
            if (start) begin
               state_in = CV_SHIFT;
               cnt_in   = '0;
               bin_in   = value;
               bcd_in   = '0;
            end
         end
         CV_SHIFT: begin
            bcd_in = {adj_bits[lbcnd_pkg::BCD_DIGITS*lbcnd_pkg::DIGIT_W-2:0],
                      bin_ff[lbcnd_pkg::VALUE_W-1]};
            bin_in = {bin_ff[lbcnd_pkg::VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + SHIFT_CNT_W'(1);
            if (cnt_ff == SHIFT_CNT_W'(lbcnd_pkg::VALUE_W - 1)) begin
               state_in = CV_COUNT;
            end
         end
         CV_COUNT: begin
            count_in = sig_count;
            state_in = CV_IDLE;
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         cnt_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digits       = bcd_ff;
   assign status.busy  = (state_ff != CV_IDLE);
   assign status.count = count_ff;

endmodule

`default_nettype wire

[hdl/led_blink_code_number_display.sv]
// Top level of the LED blink code number display.
//
// Each beat on the request channel is either a time tick or a start command,
// and each gives exactly one response beat with the LED level, the busy flag
// and the finished flag. A start taken while idle is answered as well, but
// then keeps req_ready low while the BCD converter runs its 32 shift-and-correct
// steps and one digit count step. The response sits in an output register;
// req_ready also drops while a response waits and rsp_ready is low.
// Configuration writes take effect when the next phase loads its tick count.
`default_nettype none

module led_blink_code_number_display #(
   parameter int MAX_DIGITS = 10
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  lbcnd_pkg::req_type            req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output lbcnd_pkg::rsp_type                  rsp_data,
   input  wire                                 csr_wr_en,
   input  wire  [lbcnd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [lbcnd_pkg::TICK_W-1:0]        csr_wr_data
);

   localparam int TOTAL_W = $clog2(MAX_DIGITS + 1);
   localparam int SEL_W   = (TOTAL_W > lbcnd_pkg::COUNT_W) ? TOTAL_W : lbcnd_pkg::COUNT_W;
   localparam int TW      = lbcnd_pkg::TICK_W;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_PRE_ON    = 7'b0000010,
      PH_PRE_OFF   = 7'b0000100,
      PH_PRE_BREAK = 7'b0001000,
      PH_DIG_ON    = 7'b0010000,
      PH_DIG_OFF   = 7'b0100000,
      PH_DIG_BREAK = 7'b1000000
   } phase_type;

   function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] t);
      return (t == '0) ? TW'(1) : t;
   endfunction

   logic [TW-1:0]                   fast_ff, slow_ff, break_ff;
   logic [lbcnd_pkg::PRE_W-1:0]     pre_ff;
   phase_type                       phase_ff, phase_in;
   logic [TOTAL_W-1:0]              pos_ff, pos_in;
   logic [lbcnd_pkg::DIGIT_W-1:0]   blinks_ff, blinks_in;
   logic [TW-1:0]                   ticks_ff, ticks_in;
   logic                            led_ff, led_in;
   logic                            finished_in;
   logic                            rsp_valid_ff;
   lbcnd_pkg::rsp_type              rsp_data_ff;

   lbcnd_pkg::bcd_type              digits;
   lbcnd_pkg::conv_status_type      conv_status;
   logic                            accept;
   logic                            conv_start;
   logic [TOTAL_W-1:0]              total;
   logic [TOTAL_W-1:0]              pos_adv;
   logic [TOTAL_W-1:0]              pos_next;
   logic [SEL_W-1:0]                dig_idx;
   logic [lbcnd_pkg::DIGIT_W-1:0]   digit;
   logic [lbcnd_pkg::DIGIT_W-1:0]   blinks_dec;
   logic [TW-1:0]                   fast_eff, slow_eff, break_eff, half_eff;

   assign req_ready  = !conv_status.busy && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign conv_start = accept && req_data.cmd && (phase_ff == PH_IDLE);

   lbcnd_bcd_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_data.value),
      .digits (digits),
      .status (conv_status)
   );

   // Only the least significant MAX_DIGITS digits are shown.
   assign total = (SEL_W'(conv_status.count) > SEL_W'(MAX_DIGITS))
                  ? TOTAL_W'(MAX_DIGITS) : TOTAL_W'(conv_status.count);

   assign fast_eff  = at_least_one(fast_ff);
   assign slow_eff  = at_least_one(slow_ff);
   assign break_eff = at_least_one(break_ff);

   // Digit position that the next phase works on; digits are shown most
   // significant first, so position p maps to BCD digit total-1-p.
   always_comb begin
      case (phase_ff)
         PH_PRE_BREAK: pos_adv = '0;
         PH_DIG_BREAK: pos_adv = pos_ff + TOTAL_W'(1);
         default:      pos_adv = pos_ff;
      endcase
   end

   assign dig_idx = SEL_W'(total) - SEL_W'(1) - SEL_W'(pos_adv);

   always_comb begin
      digit = '0;
      for (int i = 0; i < lbcnd_pkg::BCD_DIGITS; i++) begin
         if (dig_idx == SEL_W'(i)) begin
            digit = digits[i];
         end
      end
   end

   assign half_eff   = (digit == '0) ? fast_eff : slow_eff;
   assign blinks_dec = (blinks_ff != '0) ? blinks_ff - lbcnd_pkg::DIGIT_W'(1) : '0;
   assign pos_next   = pos_ff + TOTAL_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      blinks_in   = blinks_ff;
      ticks_in    = ticks_ff;
      led_in      = led_ff;
      finished_in = 1'b0;
      if (accept) begin
         if (req_data.cmd) begin
            if (phase_ff == PH_IDLE) begin
               pos_in    = '0;
               blinks_in = pre_ff;
               if (pre_ff != '0) begin
                  phase_in = PH_PRE_ON;
                  led_in   = 1'b1;
                  ticks_in = fast_eff;
               end else begin
                  phase_in = PH_PRE_BREAK;
                  led_in   = 1'b0;
                  ticks_in = break_eff;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            if (ticks_ff > TW'(1)) begin
               ticks_in = ticks_ff - TW'(1);
            end else begin
               case (phase_ff)
                  PH_PRE_ON: begin
                     phase_in = PH_PRE_OFF;
                     led_in   = 1'b0;
                     ticks_in = fast_eff;
                  end
                  PH_PRE_OFF: begin
                     blinks_in = blinks_dec;
                     if (blinks_dec != '0) begin
                        phase_in = PH_PRE_ON;
                        led_in   = 1'b1;
                        ticks_in = fast_eff;
                     end else begin
                        phase_in = PH_PRE_BREAK;
                        led_in   = 1'b0;
                        ticks_in = break_eff;
                     end
                  end
                  PH_PRE_BREAK: begin
                     pos_in    = '0;
                     phase_in  = PH_DIG_ON;
                     blinks_in = (digit == '0) ? lbcnd_pkg::DIGIT_W'(1) : digit;
                     led_in    = 1'b1;
                     ticks_in  = half_eff;
                  end
                  PH_DIG_ON: begin
                     phase_in = PH_DIG_OFF;
                     led_in   = 1'b0;
                     ticks_in = half_eff;
                  end
                  PH_DIG_OFF: begin
                     blinks_in = blinks_dec;
                     if (blinks_dec != '0) begin
                        phase_in = PH_DIG_ON;
                        led_in   = 1'b1;
                        ticks_in = half_eff;
                     end else begin
                        phase_in = PH_DIG_BREAK;
                        led_in   = 1'b0;
                        ticks_in = break_eff;
                     end
                  end
                  PH_DIG_BREAK: begin
                     pos_in = pos_next;
                     if (pos_next < total) begin
                        phase_in  = PH_DIG_ON;
                        blinks_in = (digit == '0) ? lbcnd_pkg::DIGIT_W'(1) : digit;
                        led_in    = 1'b1;
                        ticks_in  = half_eff;
                     end else begin
                        phase_in    = PH_IDLE;
                        led_in      = 1'b0;
                        ticks_in    = '0;
                        blinks_in   = '0;
                        finished_in = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     led_in   = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff      <= lbcnd_pkg::FAST_HALF_RESET;
         slow_ff      <= lbcnd_pkg::SLOW_HALF_RESET;
         break_ff     <= lbcnd_pkg::BREAK_RESET;
         pre_ff       <= lbcnd_pkg::PREAMBLE_RESET;
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         blinks_ff    <= '0;
         ticks_ff     <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lbcnd_pkg::CSR_FAST_HALF: fast_ff  <= csr_wr_data;
               lbcnd_pkg::CSR_SLOW_HALF: slow_ff  <= csr_wr_data;
               lbcnd_pkg::CSR_BREAK:     break_ff <= csr_wr_data;
               lbcnd_pkg::CSR_PREAMBLE:  pre_ff   <= csr_wr_data[lbcnd_pkg::PRE_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         blinks_ff <= blinks_in;
         ticks_ff  <= ticks_in;
         led_ff    <= led_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.led_on   <= led_in;
         rsp_data_ff.busy_res <= (phase_in != PH_IDLE);
         rsp_data_ff.finished <= finished_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A start taken while idle must hand the value to the converter.
   a_start_converts: assert property (@(posedge clock) disable iff (reset)
      conv_start |=> conv_status.busy)
      else $error("start did not launch the BCD conversion");

   // The LED is lit only in the on half of a blink.
   a_led_phase: assert property (@(posedge clock) disable iff (reset)
      led_ff |-> (phase_ff == PH_PRE_ON || phase_ff == PH_DIG_ON))
      else $error("LED lit outside an on half");

   // Every active phase holds a loaded tick count.
   a_ticks_loaded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (ticks_ff != '0))
      else $error("active phase with an empty tick count");

   // The finishing beat leaves the block idle and dark.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.finished)
         |-> (!rsp_data_ff.busy_res && !rsp_data_ff.led_on && phase_ff == PH_IDLE))
      else $error("finished beat while still busy");

endmodule

`default_nettype wire
